FILE: sv/vertex_directional_lighting_core_defines.svh
// ----------------------------------------------------------------------------
// Vertex directional lighting: assertion macros
// Shared assertion wrappers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef VERTEX_DIRECTIONAL_LIGHTING_CORE_DEFINES_SVH
`define VERTEX_DIRECTIONAL_LIGHTING_CORE_DEFINES_SVH

// plain property that must hold at every edge
`define VDL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define VDL_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VDL_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/vdl_pkg.sv
// ----------------------------------------------------------------------------
// Vertex directional lighting package
// Command codes, register indexes and datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package vdl_pkg;

  // command carried in tuser
  localparam int OP_W = 3;
  typedef enum logic [OP_W-1:0] {
    OP_ADD_LIGHT = 3'd0,
    OP_AMBIENT   = 3'd1,
    OP_DIFFUSE   = 3'd2,
    OP_CLR_MAT   = 3'd3,
    OP_CLR_ALL   = 3'd4,
    OP_SHADE     = 3'd5
  } op_e;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TINT_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TINT_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TINT_BLUE  = 2'd2;

  // field widths
  localparam int VEC_W = 16;
  localparam int COL_W = 8;
  localparam int IDX_W = 16;
  localparam logic [COL_W-1:0] COL_MAX = 8'hFF;

  localparam int IN_TDATA_W  = 3 * VEC_W + 4 * COL_W + IDX_W;  // 96
  localparam int OUT_TDATA_W = IDX_W + 4 * COL_W;              // 48

  // datapath: dot product of three 16x16 products, signed
  localparam int DOT_W  = 2 * VEC_W + 2;
  localparam int MULA_W = DOT_W;
  localparam int MULB_W = VEC_W + 1;
  localparam int MUL_W  = MULA_W + MULB_W;
  // running channel sum; bounded by MAX_LIGHTS * 254 * 3 * 4 plus base
  localparam int ACC_W  = 32;

endpackage

`default_nettype wire

FILE: sv/vertex_directional_lighting_core.sv
// ----------------------------------------------------------------------------
// Vertex directional lighting core
// Per-vertex Lambert lighting against a small table of directional lights.
//
// Input stream: tuser carries the command, tdata the vector, color and vertex
// slot, tlast marks the last vertex of a draw. Table, material and clear
// commands take effect in the accept cycle and produce no item. A shade
// command produces one output item (slot, RGBA, tlast).
// One shared 34x17 signed multiplier does all multiplications under a step
// sequencer: three steps for the base color, then per light three steps for
// the dot product, three for diffuse*light color and three for the scaling,
// then the drain and done states to drain and clamp. Without a material or
// lights loaded, a shade item skips the light steps. Input tready is low
// from the accept of a shade item until its result is loaded for output.
// The output register holds a finished item; while the receiver stalls the
// core still accepts commands, and a second shade item waits in its final
// step until the output register frees.
// Reset clears the light table count, the material and the output valid, and
// sets the three tint registers to 255.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vertex_directional_lighting_core_defines.svh"

module vertex_directional_lighting_core #(
  parameter int MAX_LIGHTS    = 7,
  parameter int VEC_FRAC_BITS = 14
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // input items
  input  wire logic                                 s_axis_tvalid_i,
  output      logic                                 s_axis_tready_o,
  // vec_x, vec_y, vec_z, col_red, col_green, col_blue, col_alpha, vertex_index
  input  wire logic [vdl_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  // op
  input  wire logic [vdl_pkg::OP_W-1:0]             s_axis_tuser_i,
  input  wire logic                                 s_axis_tlast_i,
  // output items
  output      logic                                 m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  // out_index, out_red, out_green, out_blue, out_alpha
  output      logic [vdl_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output      logic                                 m_axis_tlast_o,
  // configuration writes
  input  wire logic                                 cfg_we_i,
  input  wire logic [vdl_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [vdl_pkg::COL_W-1:0]            cfg_data_i
);

  localparam int LCNT_W = $clog2(MAX_LIGHTS + 1);
  localparam int LIDX_W = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int SHIFT  = 2 * VEC_FRAC_BITS;

  localparam int VEC_W  = vdl_pkg::VEC_W;
  localparam int COL_W  = vdl_pkg::COL_W;
  localparam int IDX_W  = vdl_pkg::IDX_W;
  localparam int DOT_W  = vdl_pkg::DOT_W;
  localparam int MULA_W = vdl_pkg::MULA_W;
  localparam int MULB_W = vdl_pkg::MULB_W;
  localparam int MUL_W  = vdl_pkg::MUL_W;
  localparam int ACC_W  = vdl_pkg::ACC_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // multiplier steps
  localparam logic [3:0] PH_B0 = 4'd0;   // ambient * tint
  localparam logic [3:0] PH_B1 = 4'd1;
  localparam logic [3:0] PH_B2 = 4'd2;
  localparam logic [3:0] PH_D0 = 4'd3;   // normal * light direction
  localparam logic [3:0] PH_D1 = 4'd4;
  localparam logic [3:0] PH_D2 = 4'd5;
  localparam logic [3:0] PH_P0 = 4'd6;   // diffuse * light color
  localparam logic [3:0] PH_P1 = 4'd7;
  localparam logic [3:0] PH_P2 = 4'd8;
  localparam logic [3:0] PH_S0 = 4'd9;   // product * dot
  localparam logic [3:0] PH_S1 = 4'd10;
  localparam logic [3:0] PH_S2 = 4'd11;

  // --------------------------------------------------------------------------
  // input unpacking
  // --------------------------------------------------------------------------
  logic                    s_fire;
  vdl_pkg::op_e            in_op;
  logic [2:0][VEC_W-1:0]   in_vec;
  logic [3:0][COL_W-1:0]   in_col;
  logic [IDX_W-1:0]        in_idx;

  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op  = vdl_pkg::op_e'(s_axis_tuser_i);
  assign in_vec = s_axis_tdata_i[3*VEC_W-1:0];
  assign in_col = s_axis_tdata_i[3*VEC_W+4*COL_W-1:3*VEC_W];
  assign in_idx = s_axis_tdata_i[vdl_pkg::IN_TDATA_W-1:3*VEC_W+4*COL_W];

  // --------------------------------------------------------------------------
  // state registers
  // --------------------------------------------------------------------------
  logic [1:0]              state_q, state_d;
  logic [3:0]              phase_q, phase_d;
  logic [LIDX_W-1:0]       light_q, light_d;
  logic [LCNT_W-1:0]       light_total_q;
  logic                    material_q;
  logic [3:0][COL_W-1:0]   amb_q;
  logic [2:0][COL_W-1:0]   dif_q;
  logic [2:0][COL_W-1:0]   tint_q;
  logic                    out_vld_q;
  logic                    tag_vld_q;
  logic [3:0]              tag_q;

  // light table, only entries below light_total_q are read
  logic [2:0][COL_W-1:0]   light_col_q [MAX_LIGHTS];
  logic [2:0][VEC_W-1:0]   light_dir_q [MAX_LIGHTS];

  // latched shade item
  logic [2:0][VEC_W-1:0]   vec_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    last_q;

  // datapath registers
  logic signed [MUL_W-1:0] mul_q;
  logic signed [DOT_W-1:0] dot_q;
  logic [2:0][COL_W-1:0]   prod_q;
  logic [2:0][COL_W-1:0]   base_q;
  logic signed [ACC_W-1:0] acc_q [3];

  logic [vdl_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic                            out_last_q;

  logic                    table_full;
  logic [LCNT_W-1:0]       light_nxt;
  logic                    out_load;

  assign table_full = (light_total_q >= LCNT_W'(MAX_LIGHTS));
  assign light_nxt  = LCNT_W'(light_q) + LCNT_W'(1);
  assign out_load   = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready_i);

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    light_d = light_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && in_op == vdl_pkg::OP_SHADE) begin
          state_d = ST_RUN;
          phase_d = PH_B0;
          light_d = '0;
        end
      end
      ST_RUN: begin
        if (phase_q == PH_B2) begin
          if (material_q && light_total_q != '0) begin
            phase_d = PH_D0;
          end else begin
            state_d = ST_DRAIN;
          end
        end else if (phase_q == PH_S2) begin
          if (light_nxt < light_total_q) begin
            phase_d = PH_D0;
            light_d = light_nxt[LIDX_W-1:0];
          end else begin
            state_d = ST_DRAIN;
          end
        end else begin
          phase_d = phase_q + 4'd1;
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_B0;
      light_q   <= '0;
      tag_vld_q <= 1'b0;
      tag_q     <= PH_B0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      light_q   <= light_d;
      tag_vld_q <= (state_q == ST_RUN);
      tag_q     <= phase_q;
    end
  end

  // --------------------------------------------------------------------------
  // commands: light count, material, tints
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_total_q <= '0;
      material_q    <= 1'b0;
      amb_q         <= '0;
      dif_q         <= '0;
      tint_q        <= {3{vdl_pkg::COL_MAX}};
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          vdl_pkg::CFG_TINT_RED:   tint_q[0] <= cfg_data_i;
          vdl_pkg::CFG_TINT_GREEN: tint_q[1] <= cfg_data_i;
          vdl_pkg::CFG_TINT_BLUE:  tint_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_fire) begin
        case (in_op)
          vdl_pkg::OP_ADD_LIGHT: begin
            if (!table_full) begin
              light_total_q <= light_total_q + LCNT_W'(1);
            end
          end
          vdl_pkg::OP_AMBIENT: begin
            amb_q      <= in_col;
            material_q <= 1'b1;
          end
          vdl_pkg::OP_DIFFUSE: begin
            dif_q      <= in_col[2:0];
            material_q <= 1'b1;
          end
          vdl_pkg::OP_CLR_MAT: begin
            amb_q      <= '0;
            dif_q      <= '0;
            material_q <= 1'b0;
          end
          vdl_pkg::OP_CLR_ALL: begin
            amb_q         <= '0;
            dif_q         <= '0;
            material_q    <= 1'b0;
            light_total_q <= '0;
            tint_q        <= {3{vdl_pkg::COL_MAX}};
          end
          default: ;
        endcase
      end
    end
  end

  // light table write and shade item latch
  always_ff @(posedge clk_i) begin
    if (s_fire && in_op == vdl_pkg::OP_ADD_LIGHT && !table_full) begin
      light_col_q[light_total_q[LIDX_W-1:0]] <= in_col[2:0];
      light_dir_q[light_total_q[LIDX_W-1:0]] <= in_vec;
    end
    if (s_fire && in_op == vdl_pkg::OP_SHADE) begin
      vec_q  <= in_vec;
      idx_q  <= in_idx;
      last_q <= s_axis_tlast_i;
    end
  end

  // --------------------------------------------------------------------------
  // shared multiplier: operand select by step
  // --------------------------------------------------------------------------
  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [MUL_W-1:0]  mul_d;
  logic [2:0][COL_W-1:0]    lcol;
  logic [2:0][VEC_W-1:0]    ldir;

  assign lcol = light_col_q[light_q];
  assign ldir = light_dir_q[light_q];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (phase_q)
      PH_B0, PH_B1, PH_B2: begin
        mul_a = $signed({{(MULA_W-COL_W){1'b0}}, amb_q[phase_q[1:0]]});
        mul_b = $signed({{(MULB_W-COL_W){1'b0}}, tint_q[phase_q[1:0]]});
      end
      PH_D0: begin
        mul_a = $signed({{(MULA_W-VEC_W){vec_q[0][VEC_W-1]}}, vec_q[0]});
        mul_b = $signed({{(MULB_W-VEC_W){ldir[0][VEC_W-1]}}, ldir[0]});
      end
      PH_D1: begin
        mul_a = $signed({{(MULA_W-VEC_W){vec_q[1][VEC_W-1]}}, vec_q[1]});
        mul_b = $signed({{(MULB_W-VEC_W){ldir[1][VEC_W-1]}}, ldir[1]});
      end
      PH_D2: begin
        mul_a = $signed({{(MULA_W-VEC_W){vec_q[2][VEC_W-1]}}, vec_q[2]});
        mul_b = $signed({{(MULB_W-VEC_W){ldir[2][VEC_W-1]}}, ldir[2]});
      end
      PH_P0: begin
        mul_a = $signed({{(MULA_W-COL_W){1'b0}}, dif_q[0]});
        mul_b = $signed({{(MULB_W-COL_W){1'b0}}, lcol[0]});
      end
      PH_P1: begin
        mul_a = $signed({{(MULA_W-COL_W){1'b0}}, dif_q[1]});
        mul_b = $signed({{(MULB_W-COL_W){1'b0}}, lcol[1]});
      end
      PH_P2: begin
        mul_a = $signed({{(MULA_W-COL_W){1'b0}}, dif_q[2]});
        mul_b = $signed({{(MULB_W-COL_W){1'b0}}, lcol[2]});
      end
      PH_S0: begin
        mul_a = dot_q;
        mul_b = $signed({{(MULB_W-COL_W){1'b0}}, prod_q[0]});
      end
      PH_S1: begin
        mul_a = dot_q;
        mul_b = $signed({{(MULB_W-COL_W){1'b0}}, prod_q[1]});
      end
      PH_S2: begin
        mul_a = dot_q;
        mul_b = $signed({{(MULB_W-COL_W){1'b0}}, prod_q[2]});
      end
      default: ;
    endcase
  end

  assign mul_d = MUL_W'(mul_a) * MUL_W'(mul_b);

  // scaled term, truncated toward zero
  logic signed [MUL_W-1:0] bias;
  logic signed [MUL_W-1:0] term_full;
  logic signed [ACC_W-1:0] term;

  assign bias      = mul_q[MUL_W-1] ? $signed({{(MUL_W-SHIFT){1'b0}}, {SHIFT{1'b1}}})
                                    : '0;
  assign term_full = (mul_q + bias) >>> SHIFT;
  assign term      = term_full[ACC_W-1:0];

  // --------------------------------------------------------------------------
  // result consume, one step behind the issue
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
    if (tag_vld_q) begin
      case (tag_q)
        PH_B0, PH_B1, PH_B2: begin
          base_q[tag_q[1:0]] <= material_q ? mul_q[2*COL_W-1:COL_W] : '0;
          acc_q[tag_q[1:0]]  <= material_q
                                ? $signed({{(ACC_W-COL_W){1'b0}}, mul_q[2*COL_W-1:COL_W]})
                                : '0;
        end
        PH_D0: dot_q <= mul_q[DOT_W-1:0];
        PH_D1, PH_D2: dot_q <= dot_q + mul_q[DOT_W-1:0];
        PH_P0: prod_q[0] <= mul_q[2*COL_W-1:COL_W];
        PH_P1: prod_q[1] <= mul_q[2*COL_W-1:COL_W];
        PH_P2: prod_q[2] <= mul_q[2*COL_W-1:COL_W];
        PH_S0: acc_q[0] <= acc_q[0] - term;
        PH_S1: acc_q[1] <= acc_q[1] - term;
        PH_S2: acc_q[2] <= acc_q[2] - term;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // clamp to [base, 255] and output register
  // --------------------------------------------------------------------------
  logic [2:0][COL_W-1:0] lit;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (acc_q[c] < $signed({{(ACC_W-COL_W){1'b0}}, base_q[c]})) begin
        lit[c] = base_q[c];
      end else if (acc_q[c] > $signed({{(ACC_W-COL_W){1'b0}}, vdl_pkg::COL_MAX})) begin
        lit[c] = vdl_pkg::COL_MAX;
      end else begin
        lit[c] = acc_q[c][COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {(material_q ? amb_q[3] : vdl_pkg::COL_MAX), lit[2], lit[1], lit[0],
                     idx_q};
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `VDL_ASSERT(a_light_total_range, light_total_q <= LCNT_W'(MAX_LIGHTS), "light count above table depth")
  `VDL_ASSERT_NXT(a_shade_starts, s_fire && in_op == vdl_pkg::OP_SHADE, state_q == ST_RUN, "shade item did not start the sequencer")
  `VDL_ASSERT_IMP(a_light_steps_valid, state_q == ST_RUN && phase_q >= PH_D0, material_q && (LCNT_W'(light_q) < light_total_q), "light step without material or past table end")
  `VDL_ASSERT_IMP(a_out_from_done, $rose(out_vld_q), $past(state_q) == ST_DONE, "output raised outside the final step")

endmodule

`default_nettype wire
